@@ hdl/bbpc_pkg.sv @@
// shared types and constants for the bounding box pair compare block
package bbpc_pkg;

	localparam int unsigned ACC_BITS  = 64;
	localparam int unsigned HALF_BITS = ACC_BITS / 2;

	localparam logic [ACC_BITS-1:0] ACC_ONE = ACC_BITS'(1);
	localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

	// per-dimension compare outcome
	typedef struct packed {
		logic eq;
		logic con;
		logic ovl;
	} dim_flags_t;

endpackage

@@ hdl/bbpc_dim_compare.sv @@
// per-dimension min/max selection, relation flags and extent lengths
module bbpc_dim_compare import bbpc_pkg::*; #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic signed [COORD_BITS-1:0] a_min,
	input  logic signed [COORD_BITS-1:0] a_max,
	input  logic signed [COORD_BITS-1:0] b_min,
	input  logic signed [COORD_BITS-1:0] b_max,
	output logic signed [COORD_BITS-1:0] union_lo,
	output logic signed [COORD_BITS-1:0] union_hi,
	output logic signed [COORD_BITS-1:0] inter_lo,
	output logic signed [COORD_BITS-1:0] inter_hi,
	output dim_flags_t                   flags,
	output logic        [COORD_BITS-1:0] a_span,
	output logic        [COORD_BITS-1:0] i_span
);

	logic signed [COORD_BITS:0] a_diff;
	logic signed [COORD_BITS:0] i_diff;

	always_comb begin
		union_lo = (a_min < b_min) ? a_min : b_min;
		union_hi = (a_max > b_max) ? a_max : b_max;
		inter_lo = (a_min > b_min) ? a_min : b_min;
		inter_hi = (a_max < b_max) ? a_max : b_max;

		flags.eq  = (a_min == b_min) && (a_max == b_max);
		flags.con = (a_min <= b_min) && (a_max >= b_max);
		flags.ovl = (a_min <= b_max) && (b_min <= a_max);

		// one extra bit keeps the difference exact; a positive result fits COORD_BITS
		a_diff = {a_max[COORD_BITS-1], a_max} - {a_min[COORD_BITS-1], a_min};
		i_diff = {inter_hi[COORD_BITS-1], inter_hi} - {inter_lo[COORD_BITS-1], inter_lo};

		a_span = (a_max > a_min) ? a_diff[COORD_BITS-1:0] : '0;
		i_span = (inter_hi > inter_lo) ? i_diff[COORD_BITS-1:0] : '0;
	end

endmodule

@@ hdl/bbpc_sat_mul.sv @@
// saturating product of a 64-bit running product and one extent length
module bbpc_sat_mul import bbpc_pkg::*; #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic [ACC_BITS-1:0]   acc,
	input  logic [COORD_BITS-1:0] factor,
	output logic [ACC_BITS-1:0]   product
);

	localparam int unsigned PART_BITS = HALF_BITS + COORD_BITS;
	localparam int unsigned FULL_BITS = ACC_BITS + COORD_BITS;

	logic [PART_BITS-1:0] part_lo;
	logic [PART_BITS-1:0] part_hi;
	logic [FULL_BITS-1:0] full;

	always_comb begin
		// two half-width partial products, then one wide add
		part_lo = PART_BITS'(acc[HALF_BITS-1:0]) * PART_BITS'(factor);
		part_hi = PART_BITS'(acc[ACC_BITS-1:HALF_BITS]) * PART_BITS'(factor);
		full    = {part_hi, {HALF_BITS{1'b0}}} + FULL_BITS'(part_lo);
		// a zero factor never sets the high bits, so zero wins over saturation
		product = (|full[FULL_BITS-1:ACC_BITS]) ? ACC_MAX : full[ACC_BITS-1:0];
	end

endmodule

@@ hdl/bounding_box_pair_compare_core.sv @@
// an accepted request passes the input register, then the result register, before it shows on the output
// throughput: one dimension per cycle unless the output stalls on out_ready, bounded by the combinational
// saturating multiply that closes the running-product loop between input and result register
// reset clears both valid flags and arms the running flags and products at one;
// payload registers are not reset
module bounding_box_pair_compare_core import bbpc_pkg::*; #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] a_min,
	input  logic signed [COORD_BITS-1:0] a_max,
	input  logic signed [COORD_BITS-1:0] b_min,
	input  logic signed [COORD_BITS-1:0] b_max,
	input  logic                         last_dim,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] union_lo,
	output logic signed [COORD_BITS-1:0] union_hi,
	output logic signed [COORD_BITS-1:0] inter_lo,
	output logic signed [COORD_BITS-1:0] inter_hi,
	output logic                         final_dim,
	output logic                         boxes_equal,
	output logic                         a_contains_b,
	output logic                         boxes_overlap,
	output logic        [ACC_BITS-1:0]   volume_a,
	output logic        [ACC_BITS-1:0]   overlap_volume
);

	// input register
	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] a_min_s1;
	logic signed [COORD_BITS-1:0] a_max_s1;
	logic signed [COORD_BITS-1:0] b_min_s1;
	logic signed [COORD_BITS-1:0] b_max_s1;
	logic                         last_s1;

	// result register
	logic                         valid_s2;
	logic signed [COORD_BITS-1:0] union_lo_s2;
	logic signed [COORD_BITS-1:0] union_hi_s2;
	logic signed [COORD_BITS-1:0] inter_lo_s2;
	logic signed [COORD_BITS-1:0] inter_hi_s2;
	logic                         final_s2;
	logic                         equal_s2;
	logic                         contains_s2;
	logic                         overlap_s2;
	logic        [ACC_BITS-1:0]   volume_s2;
	logic        [ACC_BITS-1:0]   ovl_vol_s2;

	// running state across the dimensions of one pair
	logic                equal_q;
	logic                contains_q;
	logic                overlap_q;
	logic [ACC_BITS-1:0] volume_q;
	logic [ACC_BITS-1:0] ovl_vol_q;

	logic signed [COORD_BITS-1:0] u_lo;
	logic signed [COORD_BITS-1:0] u_hi;
	logic signed [COORD_BITS-1:0] i_lo;
	logic signed [COORD_BITS-1:0] i_hi;
	dim_flags_t                   dflags;
	logic        [COORD_BITS-1:0] a_span;
	logic        [COORD_BITS-1:0] i_span;
	logic        [ACC_BITS-1:0]   vol_next;
	logic        [ACC_BITS-1:0]   ovl_next;
	logic                         eq_next;
	logic                         con_next;
	logic                         ov_next;

	logic load_s2;
	logic load_s1;

	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load_s2;
	assign load_s1  = in_valid && in_ready;

	bbpc_dim_compare #(
		.COORD_BITS(COORD_BITS)
	) u_dim (
		.a_min   (a_min_s1),
		.a_max   (a_max_s1),
		.b_min   (b_min_s1),
		.b_max   (b_max_s1),
		.union_lo(u_lo),
		.union_hi(u_hi),
		.inter_lo(i_lo),
		.inter_hi(i_hi),
		.flags   (dflags),
		.a_span  (a_span),
		.i_span  (i_span)
	);

	bbpc_sat_mul #(
		.COORD_BITS(COORD_BITS)
	) u_vol_mul (
		.acc    (volume_q),
		.factor (a_span),
		.product(vol_next)
	);

	bbpc_sat_mul #(
		.COORD_BITS(COORD_BITS)
	) u_ovl_mul (
		.acc    (ovl_vol_q),
		.factor (i_span),
		.product(ovl_next)
	);

	assign eq_next  = equal_q && dflags.eq;
	assign con_next = contains_q && dflags.con;
	assign ov_next  = overlap_q && dflags.ovl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			a_min_s1 <= a_min;
			a_max_s1 <= a_max;
			b_min_s1 <= b_min;
			b_max_s1 <= b_max;
			last_s1  <= last_dim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			union_lo_s2 <= u_lo;
			union_hi_s2 <= u_hi;
			inter_lo_s2 <= i_lo;
			inter_hi_s2 <= i_hi;
			final_s2    <= last_s1;
			// summary fields read zero on non-final dimensions
			equal_s2    <= last_s1 && eq_next;
			contains_s2 <= last_s1 && con_next;
			overlap_s2  <= last_s1 && ov_next;
			volume_s2   <= last_s1 ? vol_next : '0;
			ovl_vol_s2  <= last_s1 ? ovl_next : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			equal_q    <= 1'b1;
			contains_q <= 1'b1;
			overlap_q  <= 1'b1;
			volume_q   <= ACC_ONE;
			ovl_vol_q  <= ACC_ONE;
		end else if (load_s2) begin
			if (last_s1) begin
				equal_q    <= 1'b1;
				contains_q <= 1'b1;
				overlap_q  <= 1'b1;
				volume_q   <= ACC_ONE;
				ovl_vol_q  <= ACC_ONE;
			end else begin
				equal_q    <= eq_next;
				contains_q <= con_next;
				overlap_q  <= ov_next;
				volume_q   <= vol_next;
				ovl_vol_q  <= ovl_next;
			end
		end
	end

	assign out_valid      = valid_s2;
	assign union_lo       = union_lo_s2;
	assign union_hi       = union_hi_s2;
	assign inter_lo       = inter_lo_s2;
	assign inter_hi       = inter_hi_s2;
	assign final_dim      = final_s2;
	assign boxes_equal    = equal_s2;
	assign a_contains_b   = contains_s2;
	assign boxes_overlap  = overlap_s2;
	assign volume_a       = volume_s2;
	assign overlap_volume = ovl_vol_s2;

	// the final dimension re-arms every accumulator
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && last_s1 |=> equal_q && contains_q && overlap_q &&
			(volume_q == ACC_ONE) && (ovl_vol_q == ACC_ONE))
		else $error("accumulators not re-armed after final dimension");

	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !final_dim |-> !boxes_equal && !a_contains_b && !boxes_overlap &&
			(volume_a == '0) && (overlap_volume == '0))
		else $error("summary fields set on a non-final dimension");

	a_no_overlap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_dim && !boxes_overlap |-> overlap_volume == '0)
		else $error("overlap volume nonzero for disjoint boxes");

	a_equal_contains: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && boxes_equal |-> a_contains_b)
		else $error("equal boxes not reported as containing");

	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (union_lo <= inter_lo) && (inter_hi <= union_hi))
		else $error("union bounds do not enclose intersection bounds");

endmodule
